[hw/rtl/lj_pair_force_accumulate_top_assert.svh]
// assertion macros shared by the pair force accumulator modules
`ifndef LJ_PAIR_FORCE_ACCUMULATE_TOP_ASSERT_SVH
`define LJ_PAIR_FORCE_ACCUMULATE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LJPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LJPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ljpfa_pkg.sv]
// shared constants, types and register codes of the pair force accumulator
`timescale 1ns / 1ps

package ljpfa_pkg;

  localparam int FRAC_BITS  = 16;

  localparam int OFF_W      = 24;
  localparam int EPS_W      = 24;
  localparam int SIG_W      = 20;
  localparam int CUT_W      = 24;
  localparam int FORCE_W    = 40;
  localparam int R2_W       = 48;
  localparam int S2_W       = 40;
  localparam int DIV_W      = 56;
  localparam int DIV_CNT_W  = 6;
  localparam int INNER_W    = 56;
  localparam int PAIR_W     = 39;
  localparam int TMAG_W     = INNER_W + 1;
  localparam int MUL_A_W    = 61;
  localparam int MUL_B_W    = 64;
  localparam int MUL_CHUNK  = 16;
  localparam int MUL_STEPS  = MUL_B_W / MUL_CHUNK;
  localparam int MUL_CNT_W  = 2;
  localparam int MUL_ACC_W  = 64;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WELL_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_DIST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF     = 2'd2;

  localparam logic [EPS_W-1:0] EPS_RESET = 24'd65536;
  localparam logic [SIG_W-1:0] SIG_RESET = 20'd58327;
  localparam logic [CUT_W-1:0] CUT_RESET = 24'd163840;

  // smallest r2 treated as a real distance
  localparam logic [R2_W-1:0] NEAR_ZERO =
    R2_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999) / 64'd10000000000);

  localparam logic [INNER_W-1:0] INNER_CAP = {INNER_W{1'b1}};
  localparam logic [PAIR_W-1:0]  PAIR_CAP  = {PAIR_W{1'b1}};

  typedef struct packed {
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
    logic                    last;
    logic                    skip;
    logic [R2_W-1:0]         r2;
  } pair_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [R2_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic                 big;
    logic [MUL_ACC_W-1:0] acc;
  } mul_rsp_t;

endpackage

[hw/rtl/lj_pair_force_accumulate_top.sv]
// top level: config registers, front, pair queue and force back end
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | push / full            | in_offset_x, in_offset_y, in_last_pair
//  result   | pop / empty            | out_force_x, out_force_y, out_saturated
//  config   | cfg_we                 | cfg_index, cfg_wdata
//
// a pair inside the cutoff passes through the back end as three passes of the bit-serial
// divider, six 4-slice multiplies and an accumulate step. a skipped pair is popped without
// using the divider or multiplier; the front buffers up to four pairs plus two in flight
// before raising full.
// a result waits in the output register; only the next particle's emit stalls on it.
// reset is synchronous, active low, and restores the default register values.
`timescale 1ns / 1ps

module lj_pair_force_accumulate_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [ljpfa_pkg::OFF_W-1:0]    in_offset_x,
  input  logic signed [ljpfa_pkg::OFF_W-1:0]    in_offset_y,
  input  logic                                  in_last_pair,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [ljpfa_pkg::FORCE_W-1:0]  out_force_x,
  output logic signed [ljpfa_pkg::FORCE_W-1:0]  out_force_y,
  output logic                                  out_saturated,
  input  logic                                  cfg_we,
  input  logic        [ljpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ljpfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ljpfa_pkg::*;

  logic [EPS_W-1:0] eps_r;
  logic [SIG_W-1:0] sig_r;
  logic [CUT_W-1:0] cut_r;

  logic  fifo_full;
  logic  fifo_empty;
  logic  fifo_wr;
  logic  fifo_pop;
  pair_t fifo_wdata;
  pair_t fifo_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
      sig_r <= SIG_RESET;
      cut_r <= CUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WELL_DEPTH: eps_r <= EPS_W'(cfg_wdata);
        CFG_ZERO_DIST:  sig_r <= SIG_W'(cfg_wdata);
        CFG_CUTOFF:     cut_r <= CUT_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  ljpfa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .offset_x      (in_offset_x),
    .offset_y      (in_offset_y),
    .last_pair     (in_last_pair),
    .cutoff_radius (cut_r),
    .fifo_full     (fifo_full),
    .fifo_wr       (fifo_wr),
    .fifo_data     (fifo_wdata)
  );

  ljpfa_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fifo_wr),
    .wr_data (fifo_wdata),
    .full    (fifo_full),
    .rd_en   (fifo_pop),
    .rd_data (fifo_head),
    .empty   (fifo_empty)
  );

  ljpfa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .well_depth    (eps_r),
    .zero_distance (sig_r),
    .fifo_empty    (fifo_empty),
    .fifo_head     (fifo_head),
    .fifo_pop      (fifo_pop),
    .pop           (pop),
    .empty         (empty),
    .force_x       (out_force_x),
    .force_y       (out_force_y),
    .saturated     (out_saturated)
  );

endmodule

[hw/rtl/ljpfa_div.sv]
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ljpfa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ljpfa_pkg::div_req_t req,
  output ljpfa_pkg::div_rsp_t rsp
);
  import ljpfa_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     n_r;
  logic [DIV_W-1:0]     quo_r;
  logic [R2_W-1:0]      rem_r;
  logic [R2_W-1:0]      den_r;

  logic [R2_W:0]        rem_sh;
  logic                 ge;
  logic [R2_W-1:0]      rem_nxt;

  assign rem_sh  = {rem_r, n_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? R2_W'(rem_sh - {1'b0, den_r}) : R2_W'(rem_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      n_r   <= req.num;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

[hw/rtl/ljpfa_mul.sv]
// multi-cycle multiplier, one 16-bit slice of b per cycle, msb slice first
`timescale 1ns / 1ps

module ljpfa_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  ljpfa_pkg::mul_req_t req,
  output ljpfa_pkg::mul_rsp_t rsp
);
  import ljpfa_pkg::*;

  localparam int SUM_W = MUL_ACC_W + MUL_CHUNK + 1;

  logic                   busy_r;
  logic                   done_r;
  logic [MUL_CNT_W-1:0]   cnt_r;
  logic [MUL_A_W-1:0]     a_r;
  logic [MUL_B_W-1:0]     b_r;
  logic [MUL_ACC_W-1:0]   acc_r;
  logic                   big_r;

  logic [MUL_CHUNK-1:0]         chunk;
  logic [MUL_A_W+MUL_CHUNK-1:0] prod;
  logic [SUM_W-1:0]             sum;

  assign chunk = b_r[MUL_B_W-1 -: MUL_CHUNK];
  assign prod  = a_r * chunk;
  assign sum   = {1'b0, acc_r, {MUL_CHUNK{1'b0}}} + SUM_W'(prod);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // big marks a product of 2^64 or more, sticky across slices
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
      big_r <= 1'b0;
    end else if (busy_r) begin
      a_r   <= a_r;
      b_r   <= b_r << MUL_CHUNK;
      acc_r <= sum[MUL_ACC_W-1:0];
      big_r <= big_r | (sum[SUM_W-1:MUL_ACC_W] != '0);
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.big  = big_r;
  assign rsp.acc  = acc_r;

endmodule

[hw/rtl/ljpfa_fifo.sv]
// short queue of classified pairs between front and back
`timescale 1ns / 1ps

module ljpfa_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ljpfa_pkg::pair_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output ljpfa_pkg::pair_t rd_data,
  output logic             empty
);
  import ljpfa_pkg::*;

  `include "lj_pair_force_accumulate_top_assert.svh"

  pair_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_PTR_W:0]   cnt_r;

  assign full    = cnt_r == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

  `LJPFA_ASSERT_NOW(a_fifo_no_underflow, clk, rst_n, rd_en, cnt_r != '0, "fifo read while empty")
  `LJPFA_ASSERT_NOW(a_fifo_no_overflow, clk, rst_n, wr_en, cnt_r != (FIFO_PTR_W+1)'(FIFO_DEPTH), "fifo write while full")
  `LJPFA_ASSERT_NOW(a_fifo_cnt_range, clk, rst_n, 1'b1, cnt_r <= (FIFO_PTR_W+1)'(FIFO_DEPTH), "fifo count out of range")

endmodule

[hw/rtl/ljpfa_front.sv]
// front: takes pairs, forms r2 and flags pairs beyond cutoff or at zero distance
`timescale 1ns / 1ps

module ljpfa_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [ljpfa_pkg::OFF_W-1:0]  offset_x,
  input  logic signed [ljpfa_pkg::OFF_W-1:0]  offset_y,
  input  logic                                last_pair,
  input  logic        [ljpfa_pkg::CUT_W-1:0]  cutoff_radius,
  input  logic                                fifo_full,
  output logic                                fifo_wr,
  output ljpfa_pkg::pair_t                    fifo_data
);
  import ljpfa_pkg::*;

  logic                    en;
  logic                    s1_v_r;
  logic signed [OFF_W-1:0] s1_dx_r;
  logic signed [OFF_W-1:0] s1_dy_r;
  logic                    s1_last_r;
  logic                    s2_v_r;
  logic signed [OFF_W-1:0] s2_dx_r;
  logic signed [OFF_W-1:0] s2_dy_r;
  logic                    s2_last_r;
  logic [R2_W-1:0]         sqx_r;
  logic [R2_W-1:0]         sqy_r;
  logic [R2_W-1:0]         rc2_r;

  logic signed [R2_W-1:0]  sx;
  logic signed [R2_W-1:0]  sy;
  logic [R2_W-1:0]         r2;

  // the whole front stalls when its last stage cannot drain
  assign en      = !(s2_v_r && fifo_full);
  assign full    = !en;
  assign fifo_wr = s2_v_r && !fifo_full;

  assign sx = R2_W'(s1_dx_r);
  assign sy = R2_W'(s1_dy_r);
  assign r2 = sqx_r + sqy_r;

  assign fifo_data.dx   = s2_dx_r;
  assign fifo_data.dy   = s2_dy_r;
  assign fifo_data.last = s2_last_r;
  assign fifo_data.r2   = r2;
  assign fifo_data.skip = (r2 > rc2_r) || (r2 < NEAR_ZERO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= push;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rc2_r <= R2_W'(cutoff_radius) * R2_W'(cutoff_radius);
    if (en) begin
      s1_dx_r   <= offset_x;
      s1_dy_r   <= offset_y;
      s1_last_r <= last_pair;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_last_r <= s1_last_r;
      sqx_r     <= sx * sx;
      sqy_r     <= sy * sy;
    end
  end

endmodule

[hw/rtl/ljpfa_back.sv]
// back: sequences the force of one pair through shared divider and multiplier
`timescale 1ns / 1ps

module ljpfa_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic        [ljpfa_pkg::EPS_W-1:0]   well_depth,
  input  logic        [ljpfa_pkg::SIG_W-1:0]   zero_distance,
  input  logic                                 fifo_empty,
  input  ljpfa_pkg::pair_t                     fifo_head,
  output logic                                 fifo_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [ljpfa_pkg::FORCE_W-1:0] force_x,
  output logic signed [ljpfa_pkg::FORCE_W-1:0] force_y,
  output logic                                 saturated
);
  import ljpfa_pkg::*;

  `include "lj_pair_force_accumulate_top_assert.svh"

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_Q    = 4'd1;
  localparam logic [3:0] ST_Q2   = 4'd2;
  localparam logic [3:0] ST_Q3   = 4'd3;
  localparam logic [3:0] ST_Q6   = 4'd4;
  localparam logic [3:0] ST_M    = 4'd5;
  localparam logic [3:0] ST_WX   = 4'd6;
  localparam logic [3:0] ST_FX   = 4'd7;
  localparam logic [3:0] ST_WY   = 4'd8;
  localparam logic [3:0] ST_FY   = 4'd9;
  localparam logic [3:0] ST_ACC  = 4'd10;
  localparam logic [3:0] ST_EMIT = 4'd11;

  localparam logic signed [FORCE_W-1:0] SUM_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] SUM_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  logic [3:0]                state_r;
  logic [3:0]                state_nxt;
  pair_t                     cur_r;
  logic [S2_W-1:0]           s2_r;
  logic [INNER_W-1:0]        q_r;
  logic [INNER_W-1:0]        q3_r;
  logic                      tneg_r;
  logic [MUL_A_W-1:0]        m_r;
  logic [PAIR_W-1:0]         fx_r;
  logic [PAIR_W-1:0]         fy_r;
  logic signed [FORCE_W-1:0] sum_x_r;
  logic signed [FORCE_W-1:0] sum_y_r;
  logic                      ovf_r;
  logic                      out_v_r;
  logic signed [FORCE_W-1:0] out_x_r;
  logic signed [FORCE_W-1:0] out_y_r;
  logic                      out_sat_r;

  div_req_t                  dreq;
  div_rsp_t                  drsp;
  mul_req_t                  mreq;
  mul_rsp_t                  mrsp;

  logic [INNER_W-1:0]        inner_res;
  logic                      pair_sat;
  logic [PAIR_W-1:0]         pair_res;
  logic [TMAG_W:0]           t;
  logic [TMAG_W-1:0]         tmag;
  logic [MUL_A_W-1:0]        m_calc;
  logic [OFF_W-1:0]          mag_x;
  logic [OFF_W-1:0]          mag_y;
  logic [DIV_W-1:0]          qnum;
  logic [DIV_W-1:0]          wnum_x;
  logic [DIV_W-1:0]          wnum_y;
  logic                      flag_now;
  logic                      emit;
  logic                      acc_en;
  logic signed [FORCE_W:0]   fxs;
  logic signed [FORCE_W:0]   fys;
  logic signed [FORCE_W:0]   dif_x;
  logic signed [FORCE_W:0]   dif_y;
  logic                      sat_x;
  logic                      sat_y;
  logic signed [FORCE_W-1:0] res_x;
  logic signed [FORCE_W-1:0] res_y;

  ljpfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  ljpfa_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // products of 2^64 or more clamp, as the 64-bit overflow test does
  assign inner_res = mrsp.big ? INNER_CAP : INNER_W'(mrsp.acc >> FRAC_BITS);
  assign pair_sat  = mrsp.big || ((mrsp.acc >> (PAIR_W + FRAC_BITS)) != '0);
  assign pair_res  = pair_sat ? PAIR_CAP : PAIR_W'(mrsp.acc >> FRAC_BITS);

  // t = 2*q6 - q3, q6 arriving from the multiplier
  assign t      = {1'b0, inner_res, 1'b0} - {2'b0, q3_r};
  assign tmag   = t[TMAG_W] ? TMAG_W'(-t) : TMAG_W'(t);
  assign m_calc = (MUL_A_W'(inner_res) << 4) + (MUL_A_W'(inner_res) << 3);

  assign mag_x  = cur_r.dx[OFF_W-1] ? OFF_W'(-cur_r.dx) : OFF_W'(cur_r.dx);
  assign mag_y  = cur_r.dy[OFF_W-1] ? OFF_W'(-cur_r.dy) : OFF_W'(cur_r.dy);
  assign qnum   = {s2_r, {FRAC_BITS{1'b0}}};
  assign wnum_x = {mag_x, {(2 * FRAC_BITS){1'b0}}};
  assign wnum_y = {mag_y, {(2 * FRAC_BITS){1'b0}}};

  always_comb begin
    state_nxt = state_r;
    fifo_pop  = 1'b0;
    dreq      = '0;
    mreq      = '0;
    dreq.den  = cur_r.r2;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          if (fifo_head.skip) begin
            state_nxt = fifo_head.last ? ST_EMIT : ST_IDLE;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = qnum;
            dreq.den   = fifo_head.r2;
            state_nxt  = ST_Q;
          end
        end
      end
      ST_Q: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = MUL_A_W'(drsp.quo);
          mreq.b     = MUL_B_W'(drsp.quo);
          state_nxt  = ST_Q2;
        end
      end
      ST_Q2: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = MUL_A_W'(inner_res);
          mreq.b     = MUL_B_W'(q_r);
          state_nxt  = ST_Q3;
        end
      end
      ST_Q3: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = MUL_A_W'(inner_res);
          mreq.b     = MUL_B_W'(inner_res);
          state_nxt  = ST_Q6;
        end
      end
      ST_Q6: begin
        if (mrsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = MUL_A_W'(tmag);
          mreq.b     = MUL_B_W'(well_depth);
          state_nxt  = ST_M;
        end
      end
      ST_M: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = wnum_x;
          state_nxt  = ST_WX;
        end
      end
      ST_WX: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = m_r;
          mreq.b     = MUL_B_W'(drsp.quo);
          state_nxt  = ST_FX;
        end
      end
      ST_FX: begin
        if (mrsp.done) begin
          dreq.start = 1'b1;
          dreq.num   = wnum_y;
          state_nxt  = ST_WY;
        end
      end
      ST_WY: begin
        if (drsp.done) begin
          mreq.start = 1'b1;
          mreq.a     = m_r;
          mreq.b     = MUL_B_W'(drsp.quo);
          state_nxt  = ST_FY;
        end
      end
      ST_FY: begin
        if (mrsp.done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = cur_r.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_v_r || pop) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r) inside
      ST_Q2, ST_Q3, ST_Q6, ST_M: flag_now = mrsp.done && mrsp.big;
      ST_FX, ST_FY:              flag_now = mrsp.done && pair_sat;
      default:                   flag_now = 1'b0;
    endcase
  end

  assign emit   = (state_r == ST_EMIT) && (!out_v_r || pop);
  assign acc_en = state_r == ST_ACC;

  // force sign is sign(t) times sign(offset); the sums take sum - f
  assign fxs   = (tneg_r ^ cur_r.dx[OFF_W-1]) ? -{2'b0, fx_r} : {2'b0, fx_r};
  assign fys   = (tneg_r ^ cur_r.dy[OFF_W-1]) ? -{2'b0, fy_r} : {2'b0, fy_r};
  assign dif_x = {sum_x_r[FORCE_W-1], sum_x_r} - fxs;
  assign dif_y = {sum_y_r[FORCE_W-1], sum_y_r} - fys;
  assign sat_x = dif_x[FORCE_W] != dif_x[FORCE_W-1];
  assign sat_y = dif_y[FORCE_W] != dif_y[FORCE_W-1];
  assign res_x = sat_x ? (dif_x[FORCE_W] ? SUM_MIN : SUM_MAX) : dif_x[FORCE_W-1:0];
  assign res_y = sat_y ? (dif_y[FORCE_W] ? SUM_MIN : SUM_MAX) : dif_y[FORCE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_x_r <= '0;
      sum_y_r <= '0;
      ovf_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (pop && out_v_r) begin
        out_v_r <= 1'b0;
      end
      if (emit) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        if (acc_en) begin
          sum_x_r <= res_x;
          sum_y_r <= res_y;
        end
        ovf_r <= ovf_r | flag_now | (acc_en && (sat_x || sat_y));
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= S2_W'(zero_distance) * S2_W'(zero_distance);
    if (fifo_pop) cur_r <= fifo_head;
    if (state_r == ST_Q && drsp.done) q_r <= drsp.quo;
    if (state_r == ST_Q3 && mrsp.done) q3_r <= inner_res;
    if (state_r == ST_Q6 && mrsp.done) tneg_r <= t[TMAG_W];
    if (state_r == ST_M && mrsp.done) m_r <= m_calc;
    if (state_r == ST_FX && mrsp.done) fx_r <= pair_res;
    if (state_r == ST_FY && mrsp.done) fy_r <= pair_res;
    if (emit) begin
      out_x_r   <= sum_x_r;
      out_y_r   <= sum_y_r;
      out_sat_r <= ovf_r;
    end
  end

  assign empty     = !out_v_r;
  assign force_x   = out_x_r;
  assign force_y   = out_y_r;
  assign saturated = out_sat_r;

  `LJPFA_ASSERT_NOW(a_div_start_idle, clk, rst_n, dreq.start, !drsp.busy, "divider restarted while busy")
  `LJPFA_ASSERT_NOW(a_mul_start_idle, clk, rst_n, mreq.start, !mrsp.busy, "multiplier restarted while busy")
  `LJPFA_ASSERT_NEXT(a_emit_waits, clk, rst_n, (state_r == ST_EMIT) && out_v_r && !pop, state_r == ST_EMIT, "result dropped while output held")

endmodule
